>>> hdl/mvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 3x3 matrix-vector transform
// Default widths, register indexes and the lane pipeline control bundle.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int VEC_WIDTH_DEF      = 32;
    localparam int COEF_WIDTH_DEF     = 18;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Three components per vector, three rows/columns per matrix
    localparam int NUM_LANES = 3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW0 = 2'd0,
        CFG_ROW1 = 2'd1,
        CFG_ROW2 = 2'd2
    } cfg_reg_t;

    // Per-item operating mode
    localparam logic MODE_DIRECT    = 1'b0;
    localparam logic MODE_TRANSPOSE = 1'b1;

    // Load enables for the lane pipeline registers
    typedef struct packed {
        logic adv_prod;
        logic adv_sum;
    } lane_ctrl_t;

endpackage : mvt_pkg
`default_nettype wire

>>> hdl/mvt_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_lane: one output component of the transform
// Three coefficient-by-component products, registered, then their exact sum.
// ----------------------------------------------------------------------------
module mvt_lane
    import mvt_pkg::*;
#(
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    localparam int PROD_W    = VEC_WIDTH + COEF_WIDTH,
    localparam int SUM_W     = PROD_W + 2
)
(
    input  wire                               clk,
    input  wire lane_ctrl_t                   ctrl,
    input  wire logic signed [VEC_WIDTH-1:0]  vec  [NUM_LANES],
    input  wire logic signed [COEF_WIDTH-1:0] coef [NUM_LANES],
    output logic signed [SUM_W-1:0]           sum
);

    logic signed [PROD_W-1:0] prod_reg [NUM_LANES];
    logic signed [PROD_W-1:0] prod_next [NUM_LANES];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            prod_next[j] = vec[j] * coef[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // Products are sign-extended to the full sum width; the sum is exact
    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule : mvt_lane
`default_nettype wire

>>> hdl/matrix3x3_vector_transform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3x3_vector_transform: fixed-point 3x3 matrix times vector
// Multiplies a signed Q16.16 vector by a Q2.16 coefficient matrix (or its
// transpose, chosen per item by req_type) held in three row registers. Each
// component is the exact sum of three products, rounded half-up back to the
// vector format and saturated; overflow flags any saturated component. The
// datapath is a four-stage pipeline: coefficient select, three parallel lanes
// of three multipliers each, lane sums, then a merge stage that rounds,
// saturates and combines the flags. One item is accepted every cycle while
// in_stall is low. Each stage holds its item only while the stage after it
// is full and stalled, so a stalled output still lets earlier stages fill.
// Row registers are written through the cfg port, always ready; the user
// must do so only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module matrix3x3_vector_transform
    import mvt_pkg::*;
#(
    parameter int VEC_WIDTH      = VEC_WIDTH_DEF,
    parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,

    // configuration write channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire cfg_reg_t                    cfg_index,
    input  wire logic [3*COEF_WIDTH-1:0]     cfg_data,

    // input items
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              req_type,
    input  wire logic signed [VEC_WIDTH-1:0] x_in,
    input  wire logic signed [VEC_WIDTH-1:0] y_in,
    input  wire logic signed [VEC_WIDTH-1:0] z_in,

    // result items
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic signed [VEC_WIDTH-1:0]      x_out,
    output logic signed [VEC_WIDTH-1:0]      y_out,
    output logic signed [VEC_WIDTH-1:0]      z_out,
    output logic                             overflow
);

    localparam int ROW_W  = 3 * COEF_WIDTH;
    localparam int SUM_W  = VEC_WIDTH + COEF_WIDTH + 2;
    localparam int RND_W  = SUM_W - COEF_FRAC_BITS;

    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [RND_W-1:0] RND_MAX = {{(RND_W-VEC_WIDTH+1){1'b0}},
                                            {(VEC_WIDTH-1){1'b1}}};
    localparam logic [RND_W-1:0] RND_MIN = {{(RND_W-VEC_WIDTH+1){1'b1}},
                                            {(VEC_WIDTH-1){1'b0}}};
    localparam logic [VEC_WIDTH-1:0] OUT_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic [VEC_WIDTH-1:0] OUT_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    // ------------------------------------------------------------------
    // Row registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg [NUM_LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_LANES; r++)
            begin
                row_reg[r] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW0: row_reg[0] <= cfg_data;
                CFG_ROW1: row_reg[1] <= cfg_data;
                CFG_ROW2: row_reg[2] <= cfg_data;
                default:  ; // unused index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline occupancy. A stage loads when it is empty or its successor
    // is loading in the same cycle.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || !out_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign in_stall = !rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: latch the vector and pick each lane's coefficients.
    // Lane i uses row i (direct) or column i (transpose).
    // ------------------------------------------------------------------
    logic signed [VEC_WIDTH-1:0]  vec_reg  [NUM_LANES];
    logic signed [COEF_WIDTH-1:0] coef_reg  [NUM_LANES][NUM_LANES];
    logic signed [COEF_WIDTH-1:0] coef_next [NUM_LANES][NUM_LANES];

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                if (req_type == MODE_TRANSPOSE)
                begin
                    coef_next[i][j] = row_reg[j][i*COEF_WIDTH +: COEF_WIDTH];
                end
                else
                begin
                    coef_next[i][j] = row_reg[i][j*COEF_WIDTH +: COEF_WIDTH];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            vec_reg[0] <= x_in;
            vec_reg[1] <= y_in;
            vec_reg[2] <= z_in;
            coef_reg   <= coef_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1 and 2: three lanes
    // ------------------------------------------------------------------
    lane_ctrl_t              lane_ctrl;
    logic signed [SUM_W-1:0] lane_sum [NUM_LANES];

    assign lane_ctrl.adv_prod = rdy1 && v0_reg;
    assign lane_ctrl.adv_sum  = rdy2 && v1_reg;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        mvt_lane #(
            .VEC_WIDTH  (VEC_WIDTH),
            .COEF_WIDTH (COEF_WIDTH)
        ) u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .vec  (vec_reg),
            .coef (coef_reg[g]),
            .sum  (lane_sum[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: round half-up, saturate, merge the overflow flags
    // ------------------------------------------------------------------
    logic [VEC_WIDTH-1:0] res_next [NUM_LANES];
    logic [NUM_LANES-1:0] sat_next;
    logic [VEC_WIDTH-1:0] res_reg  [NUM_LANES];
    logic                 ovf_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] biased;
        logic signed [RND_W-1:0] rnd;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            biased = lane_sum[i] + $signed(HALF);
            rnd    = biased[SUM_W-1:COEF_FRAC_BITS];
            if (rnd > $signed(RND_MAX))
            begin
                res_next[i] = OUT_MAX;
                sat_next[i] = 1'b1;
            end
            else if (rnd < $signed(RND_MIN))
            begin
                res_next[i] = OUT_MIN;
                sat_next[i] = 1'b1;
            end
            else
            begin
                res_next[i] = rnd[VEC_WIDTH-1:0];
                sat_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            res_reg <= res_next;
            ovf_reg <= |sat_next;
        end
    end

    assign out_valid = v3_reg;
    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];
    assign z_out     = res_reg[2];
    assign overflow  = ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A flagged result has at least one component pinned at a bound
    a_ovf_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            (x_out == OUT_MAX || x_out == OUT_MIN || y_out == OUT_MAX ||
             y_out == OUT_MIN || z_out == OUT_MAX || z_out == OUT_MIN))
        else $error("overflow set with no saturated component");

    // A new result only comes from an item that sat in the sum stage
    a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v2_reg))
        else $error("result appeared without a lane sum");

    // Row 0 write lands the next cycle
    a_row0_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == CFG_ROW0 |=>
            row_reg[0] == $past(cfg_data))
        else $error("row 0 register did not take the written value");

    // The input side is stalled only while every stage is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v0_reg && v1_reg && v2_reg && v3_reg && out_stall))
        else $error("input stalled with room in the pipeline");

endmodule : matrix3x3_vector_transform
`default_nettype wire
